@@ rtl/core/mnlcm_pkg.sv @@
// shared types, codes and tables for the midi note to light channel mapper
package mnlcm_pkg;

  localparam int unsigned PIN_COUNT       = 8;
  localparam int unsigned PIN_W           = 3;
  localparam int unsigned CHANNELS        = 16;
  localparam int unsigned NOTE_W          = 7;
  localparam int unsigned CHAN_W          = 4;
  localparam int unsigned PROG_W          = 7;
  localparam int unsigned CFG_W           = 4;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned MELODY_IDX_W    = 4;
  localparam int unsigned NOTE_COUNT      = 128;
  localparam int unsigned MELODY_PINS_DEF = 5;
  localparam int unsigned S_DATA_W        = 32;
  localparam int unsigned M_DATA_W        = 16;

  // instrument ranges
  localparam logic [PROG_W-1:0] PERC_LO  = 7'd8;
  localparam logic [PROG_W-1:0] PERC_HI  = 7'd15;
  localparam logic [PROG_W-1:0] BASS_LO  = 7'd32;
  localparam logic [PROG_W-1:0] BASS_HI  = 7'd39;
  localparam logic [PROG_W-1:0] SYNTH_LO = 7'd88;
  localparam logic [PROG_W-1:0] SYNTH_HI = 7'd103;

  // reset pin assignments
  localparam logic [CFG_W-1:0] PERC_PIN_RST  = 4'd5;
  localparam logic [CFG_W-1:0] BASS_PIN_RST  = 4'd6;
  localparam logic [CFG_W-1:0] SYNTH_PIN_RST = 4'd6;

  typedef enum logic [1:0] {
    ACT_PROGRAM  = 2'd0,
    ACT_NOTE_ON  = 2'd1,
    ACT_NOTE_OFF = 2'd2,
    ACT_OTHER    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERC_PIN  = 2'd0,
    CFG_BASS_PIN  = 2'd1,
    CFG_SYNTH_PIN = 2'd2,
    CFG_NONE      = 2'd3
  } cfg_index_t;

  typedef logic [MELODY_IDX_W-1:0] melody_tab_t [NOTE_COUNT];

  // melody pin for every note, built at elaboration
  function automatic melody_tab_t melody_table(int unsigned pins);
    melody_tab_t tab;
    for (int unsigned n = 0; n < NOTE_COUNT; n++) begin
      tab[n] = MELODY_IDX_W'(((n % 12) * pins) / 12);
    end
    return tab;
  endfunction

endpackage

@@ rtl/core/midi_note_to_light_channel_mapper.sv @@
// midi note to light channel mapper top level
//
//  channel  | direction | tdata fields (lsb first)
//  s_*      | in        | action[1:0] midi_channel[5:2] note_number[12:6]
//           |           | velocity[19:13] program_req[26:20], zero pad to 32
//  m_*      | out       | pin_levels[7:0] event_handled[8], zero pad to 16
//  cfg_*    | in        | cfg_index selects pin register, cfg_data 4-bit signed
//
// one request per cycle unless stalled; its result shows in the output register
// the next cycle. the state update and the result are computed in one pass
// from the request and the stored pin state, so back-to-back requests see
// each other's effects. a stalled result holds; s_tready drops only while
// the result waits. rst clears instruments, ownership flags, levels and
// toggle; owner fields are left unreset and only read while a pin is busy.
module midi_note_to_light_channel_mapper #(
  parameter int unsigned MELODY_PINS = mnlcm_pkg::MELODY_PINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // action, midi_channel, note_number, velocity, program_req
  input  logic [mnlcm_pkg::S_DATA_W-1:0]        s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // pin_levels, event_handled
  output logic [mnlcm_pkg::M_DATA_W-1:0]        m_tdata,
  input  logic                                  cfg_we,
  input  logic [mnlcm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mnlcm_pkg::CFG_W-1:0]           cfg_data
);
  import mnlcm_pkg::*;

  localparam melody_tab_t MELODY_TAB = melody_table(MELODY_PINS);

  // configuration
  logic [CFG_W-1:0] perc_pin, bass_pin, synth_pin;

  // state
  logic [PROG_W-1:0]    channel_instrument [CHANNELS];
  logic [PIN_COUNT-1:0] pin_busy, pin_busy_next;
  logic [NOTE_W-1:0]    pin_owner_note [PIN_COUNT];
  logic [CHAN_W-1:0]    pin_owner_channel [PIN_COUNT];
  logic [PIN_COUNT-1:0] pin_level, pin_level_next;
  logic                 perc_toggle, perc_toggle_next;

  // output register
  logic                 out_valid;
  logic [PIN_COUNT-1:0] out_levels;
  logic                 out_handled;

  // request fields
  action_t           action;
  logic [CHAN_W-1:0] ch;
  logic [NOTE_W-1:0] note;
  logic [NOTE_W-1:0] vel;
  logic [PROG_W-1:0] prog;

  logic                    accept;
  logic [PROG_W-1:0]       instr;
  logic                    is_perc, is_bass, is_synth;
  logic                    perc_en, bass_en, synth_en;
  logic [MELODY_IDX_W-1:0] melody_idx;
  logic [PIN_W-1:0]        pin;
  logic                    pin_ok;
  logic                    note_on;
  logic                    claim, unclaim;
  logic                    handled;

  assign action = action_t'(s_tdata[1:0]);
  assign ch     = s_tdata[5:2];
  assign note   = s_tdata[12:6];
  assign vel    = s_tdata[19:13];
  assign prog   = s_tdata[26:20];

  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign instr    = channel_instrument[ch];
  assign is_perc  = (instr >= PERC_LO) && (instr <= PERC_HI);
  assign is_bass  = (instr >= BASS_LO) && (instr <= BASS_HI);
  assign is_synth = (instr >= SYNTH_LO) && (instr <= SYNTH_HI);
  // any negative value disables a dedicated pin
  assign perc_en  = !perc_pin[CFG_W-1];
  assign bass_en  = !bass_pin[CFG_W-1];
  assign synth_en = !synth_pin[CFG_W-1];
  assign melody_idx = MELODY_TAB[note];

  always_comb begin
    pin    = '0;
    pin_ok = 1'b0;
    if (is_bass && bass_en) begin
      pin    = bass_pin[PIN_W-1:0];
      pin_ok = 1'b1;
    end else if (is_synth && synth_en) begin
      pin    = synth_pin[PIN_W-1:0];
      pin_ok = 1'b1;
    end else begin
      pin    = melody_idx[PIN_W-1:0];
      pin_ok = !melody_idx[MELODY_IDX_W-1];
    end
  end

  assign note_on = (action == ACT_NOTE_ON) && (vel != '0);

  always_comb begin
    pin_busy_next    = pin_busy;
    pin_level_next   = pin_level;
    perc_toggle_next = perc_toggle;
    claim            = 1'b0;
    unclaim          = 1'b0;
    handled          = 1'b1;
    case (action)
      ACT_PROGRAM: begin
        pin_busy_next = '0;
      end
      ACT_NOTE_ON, ACT_NOTE_OFF: begin
        if (is_perc) begin
          if (perc_en) begin
            perc_toggle_next = !perc_toggle;
            pin_level_next[perc_pin[PIN_W-1:0]] = !perc_toggle;
          end
        end else if (pin_ok) begin
          if (note_on) begin
            claim = !pin_busy[pin] || (pin_owner_channel[pin] > ch);
          end else begin
            unclaim = pin_busy[pin] && (pin_owner_note[pin] == note) &&
                      (pin_owner_channel[pin] == ch);
          end
          if (claim) begin
            pin_level_next[pin] = 1'b1;
            pin_busy_next[pin]  = 1'b1;
          end else if (unclaim) begin
            pin_level_next[pin] = 1'b0;
            pin_busy_next[pin]  = 1'b0;
          end
        end
      end
      default: begin
        handled = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perc_pin  <= PERC_PIN_RST;
      bass_pin  <= BASS_PIN_RST;
      synth_pin <= SYNTH_PIN_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PERC_PIN:  perc_pin  <= cfg_data;
        CFG_BASS_PIN:  bass_pin  <= cfg_data;
        CFG_SYNTH_PIN: synth_pin <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        channel_instrument[i] <= '0;
      end
      pin_busy    <= '0;
      pin_level   <= '0;
      perc_toggle <= 1'b0;
    end else if (accept) begin
      if (action == ACT_PROGRAM) begin
        channel_instrument[ch] <= prog;
      end
      pin_busy    <= pin_busy_next;
      pin_level   <= pin_level_next;
      perc_toggle <= perc_toggle_next;
    end
  end

  // owner fields only matter while the pin is busy
  always_ff @(posedge clk) begin
    if (accept && claim) begin
      pin_owner_note[pin]    <= note;
      pin_owner_channel[pin] <= ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_levels  <= pin_level_next;
      out_handled <= handled;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(M_DATA_W - PIN_COUNT - 1){1'b0}}, out_handled, out_levels};

endmodule
